>>> hw/rtl/pairwise_unit_literal_mailboxes_core_assert.svh
// Assertion macros for the unit-literal mailbox block.
// Included by the RTL files that carry concurrent checks; no other dependency.
`ifndef PAIRWISE_UNIT_LITERAL_MAILBOXES_CORE_ASSERT_SVH
`define PAIRWISE_UNIT_LITERAL_MAILBOXES_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define PULM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication
`define PULM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PULM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PULM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/pulm_pkg.sv
// Shared types and constants for the unit-literal mailbox block.
// No dependencies; used by pulm_ptr_mem and the top level.
package pulm_pkg;

    localparam int LIT_W = 31;
    localparam int ID_W  = 2;

    // Request codes carried in tuser
    typedef enum logic [1:0] {
        OP_EXPORT = 2'd0,
        OP_IMPORT = 2'd1,
        OP_CLEAR  = 2'd2
    } opcode_t;

    // Control strobes toward the pointer memory
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } ptr_ctl_t;

endpackage

>>> hw/rtl/pulm_ptr_mem.sv
// Head/tail pointer memory, one entry per ordered thread pair.
// Depends on pulm_pkg (ptr_ctl_t). Valid bits make cleared entries read as zero.
module pulm_ptr_mem #(
    parameter int THREADS    = 4,
    parameter int RING_DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pulm_pkg::ptr_ctl_t               ctl,
    input  logic [$clog2(THREADS*THREADS)-1:0] addr,
    input  logic [$clog2(RING_DEPTH)-1:0]    wr_head,
    input  logic [$clog2(RING_DEPTH)-1:0]    wr_tail,
    output logic [$clog2(RING_DEPTH)-1:0]    rd_head,
    output logic [$clog2(RING_DEPTH)-1:0]    rd_tail
);

    localparam int NPAIRS = THREADS * THREADS;
    localparam int PW     = $clog2(RING_DEPTH);

    logic [2*PW-1:0]   mem [NPAIRS];
    logic [NPAIRS-1:0] valid_reg;
    logic [2*PW-1:0]   rd_data_reg;
    logic              rd_vld_reg;

    // Valid bits: drop all on clear, mark on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.clr)
        begin
            valid_reg <= '0;
        end
        else if (ctl.wr)
        begin
            valid_reg[addr] <= 1'b1;
        end
    end

    // Pointer storage with registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= {wr_head, wr_tail};
        end
        if (ctl.rd)
        begin
            rd_data_reg <= mem[addr];
            rd_vld_reg  <= valid_reg[addr];
        end
    end

    // Entries not written since clear read as zero
    assign rd_head = rd_vld_reg ? rd_data_reg[2*PW-1:PW] : '0;
    assign rd_tail = rd_vld_reg ? rd_data_reg[PW-1:0]    : '0;

endmodule

>>> hw/rtl/pairwise_unit_literal_mailboxes_core.sv
// Unit-literal mailbox matrix: one ring per ordered thread pair.
// Depends on pulm_pkg, pulm_ptr_mem and the assertion macro header.
//
// Use:
//   s_axis carries requests: tuser = opcode, tdata = thread_id and literal.
//   m_axis carries import results: tdata = source thread and literal,
//   tuser = empty flag, tlast marks the final result of an import.
//   cfg_valid/cfg_data writes active_threads (taken at once, cfg_ready is high).
// Sequence:
//   Requests are handled one at a time by a sequencer around two memories.
//   Export: accept, skip the own slot, then per destination ring a pointer
//   read, then store and pointer write; a final step finishes.
//   Clear and ignored requests are done once accepted.
//   Import: accept, skip the own slot, then per source ring a pointer read,
//   pointer write and empty check, per drained literal a store read, then
//   hand-over, and a finish step; literals go through the single store read
//   port, and the drain waits while the receiver stalls.
//   First result appears once the second literal or the end is found.
// Reset: all pointers read as zero, active_threads is 4, outputs idle.
//   The ring store is not cleared; only entries between head and tail are read.
// Stall: one output register holds a result while the receiver stalls; the
//   drain waits for it, and a new request is accepted once the sequencer idles.
`include "pairwise_unit_literal_mailboxes_core_assert.svh"

module pairwise_unit_literal_mailboxes_core #(
    parameter int THREADS    = 4,
    parameter int RING_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [1:0] thread_id, [32:2] literal, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    // Result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [1:0] source_thread, [32:2] literal_res, rest zero
    output logic        m_axis_tuser,   // [0] empty_res
    output logic        m_axis_tlast,
    // Configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);

    localparam int NPAIRS = THREADS * THREADS;
    localparam int PRW    = $clog2(NPAIRS);
    localparam int PW     = $clog2(RING_DEPTH);
    localparam int SDEPTH = NPAIRS * RING_DEPTH;
    localparam int SAW    = $clog2(SDEPTH);
    localparam int CW     = $clog2(THREADS + 1);
    localparam int XW     = CW + 3;
    localparam int LW     = pulm_pkg::LIT_W;
    localparam int IW     = pulm_pkg::ID_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EX_SEL,
        ST_EX_WR,
        ST_IM_SEL,
        ST_IM_PTR,
        ST_IM_CHK,
        ST_IM_DATA,
        ST_FIN
    } state_t;

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
        nxt = (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    state_t              state_reg;
    pulm_pkg::opcode_t   op_reg;
    logic [IW-1:0]       id_reg;
    logic [LW-1:0]       lit_reg;
    logic [CW-1:0]       t_reg;
    logic [PW-1:0]       head_reg;
    logic [PW-1:0]       tail_reg;
    logic                pend_valid_reg;
    logic [IW-1:0]       pend_src_reg;
    logic [LW-1:0]       pend_lit_reg;
    logic                m_valid_reg;
    logic [IW-1:0]       m_src_reg;
    logic [LW-1:0]       m_lit_reg;
    logic                m_empty_reg;
    logic                m_last_reg;
    logic [2:0]          active_reg;

    logic [LW-1:0]       store_mem [SDEPTH];
    logic [LW-1:0]       st_rdata_reg;

    pulm_pkg::ptr_ctl_t  ptr_ctl;
    logic [PRW-1:0]      ptr_addr;
    logic [PW-1:0]       ptr_head;
    logic [PW-1:0]       ptr_tail;
    logic [PW-1:0]       wr_head;
    logic [PW-1:0]       wr_tail;

    logic [XW-1:0]       act_x;
    logic [XW-1:0]       thr_x;
    logic [XW-1:0]       n_x;
    logic [XW-1:0]       t_x;
    logic [XW-1:0]       id_x;
    logic [XW-1:0]       in_id_x;
    logic                t_done;
    logic                t_self;
    logic [PRW-1:0]      exp_pair;
    logic [PRW-1:0]      imp_pair;
    logic                ex_room;
    logic                st_we;
    logic                st_re;
    logic [SAW-1:0]      st_waddr;
    logic [SAW-1:0]      st_raddr;
    logic                in_acc;
    logic                out_free;
    logic                m_load;

    // Effective thread count and loop position
    always_comb
    begin
        act_x   = XW'(active_reg);
        thr_x   = XW'(THREADS);
        n_x     = (act_x > thr_x) ? thr_x : act_x;
        t_x     = XW'(t_reg);
        id_x    = XW'(id_reg);
        in_id_x = XW'(s_axis_tdata[IW-1:0]);
        t_done  = (t_x >= n_x);
        t_self  = (t_x == id_x);
    end

    // Memory addresses and strobes
    always_comb
    begin
        exp_pair = PRW'(int'(id_reg) * THREADS + int'(t_reg));
        imp_pair = PRW'(int'(t_reg) * THREADS + int'(id_reg));
        ptr_addr = (op_reg == pulm_pkg::OP_EXPORT) ? exp_pair : imp_pair;
        ex_room  = (nxt(ptr_tail) != ptr_head);

        ptr_ctl.rd  = ((state_reg == ST_EX_SEL) || (state_reg == ST_IM_SEL))
                      && !t_done && !t_self;
        ptr_ctl.wr  = ((state_reg == ST_EX_WR) && ex_room) || (state_reg == ST_IM_PTR);
        ptr_ctl.clr = in_acc && (s_axis_tuser == pulm_pkg::OP_CLEAR);

        wr_head = (state_reg == ST_EX_WR) ? ptr_head : ptr_tail;
        wr_tail = (state_reg == ST_EX_WR) ? nxt(ptr_tail) : ptr_tail;

        st_we    = (state_reg == ST_EX_WR) && ex_room;
        st_waddr = SAW'(int'(exp_pair) * RING_DEPTH + int'(ptr_tail));
        st_re    = (state_reg == ST_IM_CHK) && (head_reg != tail_reg);
        st_raddr = SAW'(int'(imp_pair) * RING_DEPTH + int'(head_reg));
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_load        = out_free && (((state_reg == ST_IM_DATA) && pend_valid_reg)
                                        || (state_reg == ST_FIN));

    pulm_ptr_mem #(
        .THREADS    (THREADS),
        .RING_DEPTH (RING_DEPTH)
    ) u_ptr_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ptr_ctl),
        .addr    (ptr_addr),
        .wr_head (wr_head),
        .wr_tail (wr_tail),
        .rd_head (ptr_head),
        .rd_tail (ptr_tail)
    );

    // Ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= lit_reg;
        end
        if (st_re)
        begin
            st_rdata_reg <= store_mem[st_raddr];
        end
    end

    // Thread count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 3'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_reg <= cfg_data;
        end
    end

    // Sequencer with result and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= pulm_pkg::OP_EXPORT;
            id_reg         <= '0;
            lit_reg        <= '0;
            t_reg          <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_src_reg   <= '0;
            pend_lit_reg   <= '0;
            m_valid_reg    <= 1'b0;
            m_src_reg      <= '0;
            m_lit_reg      <= '0;
            m_empty_reg    <= 1'b0;
            m_last_reg     <= 1'b0;
        end
        else
        begin
            // Raise valid on a new result, drop it once taken
            if (m_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg         <= pulm_pkg::opcode_t'(s_axis_tuser);
                        id_reg         <= s_axis_tdata[IW-1:0];
                        lit_reg        <= s_axis_tdata[IW+LW-1:IW];
                        t_reg          <= '0;
                        pend_valid_reg <= 1'b0;
                        case (s_axis_tuser)
                            pulm_pkg::OP_EXPORT:
                            begin
                                if (in_id_x < n_x)
                                begin
                                    state_reg <= ST_EX_SEL;
                                end
                            end
                            pulm_pkg::OP_IMPORT:
                            begin
                                if (in_id_x < n_x)
                                begin
                                    state_reg <= ST_IM_SEL;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                ST_EX_SEL:
                begin
                    if (t_done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (t_self)
                    begin
                        t_reg <= t_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_EX_WR;
                    end
                end

                ST_EX_WR:
                begin
                    t_reg     <= t_reg + 1'b1;
                    state_reg <= ST_EX_SEL;
                end

                ST_IM_SEL:
                begin
                    if (t_done)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else if (t_self)
                    begin
                        t_reg <= t_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_IM_PTR;
                    end
                end

                ST_IM_PTR:
                begin
                    // Ring is drained whole: head catches up with tail in memory
                    head_reg  <= ptr_head;
                    tail_reg  <= ptr_tail;
                    state_reg <= ST_IM_CHK;
                end

                ST_IM_CHK:
                begin
                    if (head_reg == tail_reg)
                    begin
                        t_reg     <= t_reg + 1'b1;
                        state_reg <= ST_IM_SEL;
                    end
                    else
                    begin
                        head_reg  <= nxt(head_reg);
                        state_reg <= ST_IM_DATA;
                    end
                end

                ST_IM_DATA:
                begin
                    // Hold one result back so the final one can carry tlast
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            m_src_reg   <= pend_src_reg;
                            m_lit_reg   <= pend_lit_reg;
                            m_empty_reg <= 1'b0;
                            m_last_reg  <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_src_reg   <= IW'(t_reg);
                        pend_lit_reg   <= st_rdata_reg;
                        state_reg      <= ST_IM_CHK;
                    end
                end

                ST_FIN:
                begin
                    if (out_free)
                    begin
                        m_src_reg      <= pend_valid_reg ? pend_src_reg : '0;
                        m_lit_reg      <= pend_valid_reg ? pend_lit_reg : '0;
                        m_empty_reg    <= !pend_valid_reg;
                        m_last_reg     <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(40 - IW - LW){1'b0}}, m_lit_reg, m_src_reg};
    assign m_axis_tuser  = m_empty_reg;
    assign m_axis_tlast  = m_last_reg;

    // A pointer read is always followed by its consuming step
    `PULM_ASSERT_NXT(a_ptr_rd_follow, clk, rst_n, ptr_ctl.rd, (state_reg == ST_EX_WR) || (state_reg == ST_IM_PTR))
    // An empty result is always the final one
    `PULM_ASSERT_IMP(a_empty_last, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
    // Finishing with nothing held back yields an empty result
    `PULM_ASSERT_NXT(a_fin_empty, clk, rst_n, (state_reg == ST_FIN) && out_free && !pend_valid_reg, m_axis_tvalid && m_axis_tuser && m_axis_tlast)
    // Draining only happens for a source inside the thread count
    `PULM_ASSERT_IMP(a_drain_range, clk, rst_n, state_reg == ST_IM_DATA, t_x < n_x)

endmodule

>>> tb/sv/pairwise_unit_literal_mailboxes_core_checker.sv
// Checker for the unit-literal mailbox block: watches the request, result and
// configuration channels, predicts every import result and compares it.
// Depends on pulm_pkg for the request codes and field widths.
module pairwise_unit_literal_mailboxes_core_checker #(
    parameter int THREADS    = 4,
    parameter int RING_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [1:0] thread_id, [32:2] literal, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // [1:0] source_thread, [32:2] literal_res, rest zero
    input  logic        m_axis_tuser,   // [0] empty_res
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    output int          mismatch_count,
    output int          pending_results
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAIRS = THREADS * THREADS;

    typedef struct packed {
        logic [pulm_pkg::ID_W-1:0]  source_thread;
        logic [pulm_pkg::LIT_W-1:0] literal_res;
        logic                       empty_res;
        logic                       last;
    } delivery_t;

    // Own copy of the mailbox matrix
    logic [pulm_pkg::LIT_W-1:0] ring_mem [PAIRS*RING_DEPTH];
    int                         head_pos [PAIRS];
    int                         tail_pos [PAIRS];
    int                         active_cfg;
    delivery_t                  due_results[$];

    // Update the mailbox copy for one request and queue the deliveries it causes
    task automatic apply_mailbox_request(input logic [1:0] op, input int id,
                                         input logic [pulm_pkg::LIT_W-1:0] lit);
        int        n;
        int        pair;
        int        pos;
        int        total;
        int        seen;
        delivery_t r;
        n = (active_cfg > THREADS) ? THREADS : active_cfg;
        if (op == pulm_pkg::OP_CLEAR) begin
            for (int p = 0; p < PAIRS; p++) begin
                head_pos[p] = 0;
                tail_pos[p] = 0;
            end
        end
        else if (op == pulm_pkg::OP_EXPORT && id < n) begin
            // Append to every ring leaving this thread; drop where full
            for (int t = 0; t < n; t++) begin
                if (t == id)
                    continue;
                pair = id * THREADS + t;
                pos  = (tail_pos[pair] + 1) % RING_DEPTH;
                if (pos == head_pos[pair])
                    continue;
                ring_mem[pair*RING_DEPTH + tail_pos[pair]] = lit;
                tail_pos[pair] = pos;
            end
        end
        else if (op == pulm_pkg::OP_IMPORT && id < n) begin
            total = 0;
            for (int t = 0; t < n; t++) begin
                if (t == id)
                    continue;
                pair  = t * THREADS + id;
                total += (tail_pos[pair] - head_pos[pair] + RING_DEPTH) % RING_DEPTH;
            end
            if (total == 0) begin
                r.source_thread = '0;
                r.literal_res   = '0;
                r.empty_res     = 1'b1;
                r.last          = 1'b1;
                due_results.push_back(r);
            end
            else begin
                // Drain in ascending source order, oldest entry first
                seen = 0;
                for (int t = 0; t < n; t++) begin
                    if (t == id)
                        continue;
                    pair = t * THREADS + id;
                    pos  = head_pos[pair];
                    while (pos != tail_pos[pair]) begin
                        seen++;
                        r.source_thread = pulm_pkg::ID_W'(t);
                        r.literal_res   = ring_mem[pair*RING_DEPTH + pos];
                        r.empty_res     = 1'b0;
                        r.last          = (seen == total);
                        due_results.push_back(r);
                        pos = (pos + 1) % RING_DEPTH;
                    end
                    head_pos[pair] = pos;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare results first, then take in configuration and requests
    always @(posedge clk or negedge rst_n) begin
        delivery_t want;
        if (!rst_n) begin
            for (int p = 0; p < PAIRS; p++) begin
                head_pos[p] = 0;
                tail_pos[p] = 0;
            end
            active_cfg = 4;
            due_results.delete();
            mismatch_count = 0;
            pending_results <= 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result: source %0d literal %0h empty %0b last %0b",
                           m_axis_tdata[1:0], m_axis_tdata[32:2], m_axis_tuser,
                           m_axis_tlast);
                    mismatch_count++;
                end
                else begin
                    want = due_results.pop_front();
                    check_field("source_thread", 32'(want.source_thread),
                                32'(m_axis_tdata[1:0]));
                    check_field("literal_res", 32'(want.literal_res),
                                32'(m_axis_tdata[32:2]));
                    check_field("empty_res", 32'(want.empty_res), 32'(m_axis_tuser));
                    check_field("last", 32'(want.last), 32'(m_axis_tlast));
                end
            end
            if (cfg_valid && cfg_ready)
                active_cfg = int'(cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                apply_mailbox_request(s_axis_tuser, int'(s_axis_tdata[1:0]),
                                      s_axis_tdata[32:2]);
            pending_results <= due_results.size();
        end
    end

endmodule

>>> tb/sv/pairwise_unit_literal_mailboxes_core_tb.sv
// Top of the mailbox block testbench: clock, reset, request and result traffic,
// configuration phases and the verdict. Depends on pulm_pkg, the block and
// pairwise_unit_literal_mailboxes_core_checker.
module pairwise_unit_literal_mailboxes_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          THREADS      = 4;
    localparam int          RING_DEPTH   = 16;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [30:0] LIT_MAX      = 31'h7FFF_FFFF;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          SIDE_REQ     = 0;
    localparam int          SIDE_RES     = 1;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;
    int          mismatch_count;
    int          pending_results;
    int          active_now;
    int          quiet_left [2];

    always #5 clk = ~clk;

    pairwise_unit_literal_mailboxes_core #(
        .THREADS    (THREADS),
        .RING_DEPTH (RING_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    pairwise_unit_literal_mailboxes_core_checker #(
        .THREADS    (THREADS),
        .RING_DEPTH (RING_DEPTH)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Idle gap for one item; now and then start a stretch with no gaps
    function automatic int pick_gap(input int side);
        if (quiet_left[side] > 0) begin
            quiet_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            quiet_left[side] = $urandom_range(10, 30);
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [30:0] rand_literal();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return LIT_MAX;
            2:       return 31'($urandom_range(1, 255));
            default: return 31'($urandom);
        endcase
    endfunction

    // Offer one request and hold it until taken; valid stays up for a following one
    task automatic send_request(input logic [1:0] op, input logic [1:0] id,
                                input logic [30:0] lit);
        int gap;
        gap = pick_gap(SIDE_REQ);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'b0, lit, id};
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Drop valid, wait for every expected result, then let the sequencer finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_active(input logic [2:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        active_now = int'(value);
    endtask

    // One configuration setting followed by random traffic
    task automatic run_phase(input logic [2:0] setting, input int budget,
                             input int export_pct);
        int         useful;
        int         tries;
        int         pick;
        int         n;
        logic [1:0] op;
        logic [1:0] id;
        settle();
        write_active(setting);
        n      = (active_now > THREADS) ? THREADS : active_now;
        useful = 0;
        tries  = 0;
        while (useful < budget && tries < 4 * budget) begin
            pick = $urandom_range(0, 99);
            if (pick < export_pct)
                op = pulm_pkg::OP_EXPORT;
            else if (pick < 95)
                op = pulm_pkg::OP_IMPORT;
            else if (pick < 98)
                op = pulm_pkg::OP_CLEAR;
            else
                op = OP_UNUSED;
            id = 2'($urandom_range(0, 3));
            if (op == pulm_pkg::OP_CLEAR
                || ((op == pulm_pkg::OP_EXPORT || op == pulm_pkg::OP_IMPORT) && id < n))
                useful++;
            tries++;
            send_request(op, id, rand_literal());
        end
    endtask

    // Directed requests under the reset setting of four threads
    task automatic run_directed();
        send_request(pulm_pkg::OP_IMPORT, 2'd0, '0);
        send_request(pulm_pkg::OP_EXPORT, 2'd0, '0);
        send_request(pulm_pkg::OP_EXPORT, 2'd1, LIT_MAX);
        send_request(pulm_pkg::OP_EXPORT, 2'd3, 31'h2AAA_AAAA);
        send_request(pulm_pkg::OP_EXPORT, 2'd2, 31'h5555_5555);
        send_request(pulm_pkg::OP_IMPORT, 2'd1, '0);
        send_request(pulm_pkg::OP_IMPORT, 2'd2, '0);
        send_request(pulm_pkg::OP_IMPORT, 2'd0, '0);
        send_request(OP_UNUSED, 2'd1, LIT_MAX);
        send_request(pulm_pkg::OP_EXPORT, 2'd3, 31'd7);
        send_request(pulm_pkg::OP_CLEAR, 2'd3, LIT_MAX);
        send_request(pulm_pkg::OP_IMPORT, 2'd0, '0);
        // Overfill the rings leaving thread 1: the last export is dropped
        for (int k = 1; k <= RING_DEPTH; k++)
            send_request(pulm_pkg::OP_EXPORT, 2'd1, 31'(k * 1000 + 3));
        send_request(pulm_pkg::OP_IMPORT, 2'd0, '0);
    endtask

    // Result side: stall at random, hold ready across back-to-back results
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever begin
            gap = pick_gap(SIDE_RES);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        quiet_left[SIDE_REQ] = 0;
        quiet_left[SIDE_RES] = 0;
        active_now           = 4;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= pulm_pkg::OP_EXPORT;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_phase(3'd4, 50, 60);
        run_phase(3'd4, 35, 85);
        run_phase(3'd1, 10, 60);
        run_phase(3'd2, 30, 70);
        run_phase(3'd3, 35, 60);
        run_phase(3'd0, 5, 60);
        run_phase(3'd7, 35, 85);
        run_phase(3'd5, 30, 50);
        run_phase(3'd2, 20, 90);
        run_phase(3'd4, 50, 55);
        settle();

        if (mismatch_count == 0 && pending_results == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> pairwise_unit_literal_mailboxes_core.f
+incdir+hw/rtl
hw/rtl/pulm_pkg.sv
hw/rtl/pulm_ptr_mem.sv
hw/rtl/pairwise_unit_literal_mailboxes_core.sv
tb/sv/pairwise_unit_literal_mailboxes_core_checker.sv
tb/sv/pairwise_unit_literal_mailboxes_core_tb.sv
